// ----- rtl/trc_pkg.sv -----
package trc_pkg;

  // Item action codes
  localparam logic [1:0] ACT_HEADER = 2'd0;
  localparam logic [1:0] ACT_BYTE   = 2'd1;
  localparam logic [1:0] ACT_END    = 2'd2;

  // Pattern seeding and mixing constants
  localparam logic [31:0] SALT_DOWNLOAD = 32'hA5A55A5A;
  localparam logic [31:0] SALT_UPLOAD   = 32'h5A5AA5A5;
  localparam logic [31:0] STREAM_MULT   = 32'h045D9F3B;
  localparam logic [31:0] MIX_MULT      = 32'h85EBCA6B;
  localparam int          MIX_SHIFT     = 13;

  // Jitter filter: 8 fractional bits, gain 1/16, difference saturates at 56 bits
  localparam int FRAC_BITS    = 8;
  localparam int JITTER_SHIFT = 4;
  localparam int DIFF_BITS    = 56;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] sequence_req;
    logic [31:0] flow_id;
    logic        is_download;
    logic        is_warmup;
    logic [15:0] payload_length;
    logic [63:0] send_time_us;
    logic [63:0] arrival_time_us;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] byte_count;
    logic [63:0] packet_count;
    logic [63:0] valid_count;
    logic [63:0] lost_count;
    logic [63:0] duplicate_count;
    logic [63:0] out_of_order_count;
    logic [63:0] error_count;
    logic [63:0] jitter_avg_us;
    logic        final_report;
  } out_item_t;

  // Captured item with the header-only precomputation already done
  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] sequence_req;
    logic [31:0] seed;
    logic        is_warmup;
    logic [15:0] payload_length;
    logic        send_valid;
    logic [63:0] transit;
    logic [7:0]  data_byte;
  } stg_item_t;

  // Pattern generator request: frame seed and byte position
  typedef struct packed {
    logic [31:0] seed;
    logic [15:0] index;
  } pat_req_t;

endpackage

// ----- rtl/trc_in_if.sv -----
interface trc_in_if;
  import trc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/trc_out_if.sv -----
interface trc_out_if;
  import trc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/traffic_receive_checker.sv -----
// Path: a transaction that causes a result is accepted into the capture register, then the
// state update writes the result register; a full result register can stall between the two.
// Throughput: one input transaction per cycle;
// input stalls only while the result register holds an untaken result.
// Reset: rst_n synchronous, active low; clears all counters, jitter, sequence and frame state.
module traffic_receive_checker (
  input  logic      clk,
  input  logic      rst_n,
  trc_in_if.sink    in_stream,
  trc_out_if.source out_stream
);
  import trc_pkg::*;

  logic       stg_vld;
  stg_item_t  stg_item;
  logic       adv;
  pat_req_t   pat_req;
  logic [7:0] pattern_byte;

  trc_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .adv       (adv),
    .stg_vld   (stg_vld),
    .stg_item  (stg_item)
  );

  trc_pattern u_pattern (
    .pat_req      (pat_req),
    .pattern_byte (pattern_byte)
  );

  trc_update u_update (
    .clk          (clk),
    .rst_n        (rst_n),
    .stg_vld      (stg_vld),
    .stg_item     (stg_item),
    .pattern_byte (pattern_byte),
    .pat_req      (pat_req),
    .adv          (adv),
    .out_stream   (out_stream)
  );

endmodule

// ----- rtl/trc_capture.sv -----
module trc_capture (
  input  logic               clk,
  input  logic               rst_n,
  trc_in_if.sink             in_stream,
  input  logic               adv,
  output logic               stg_vld,
  output trc_pkg::stg_item_t stg_item
);
  import trc_pkg::*;

  logic      stg_vld_r;
  logic      stg_vld_nxt;
  stg_item_t stg_item_r;
  stg_item_t stg_item_nxt;
  logic      in_accept;
  logic [31:0] sid_mix;
  logic [31:0] salt;

  assign in_stream.ready = !stg_vld_r || adv;
  assign in_accept       = in_stream.valid && in_stream.ready;

  // Seed fold and transit time, both independent of block state
  always_comb begin
    sid_mix = in_stream.payload.flow_id * STREAM_MULT;
    salt    = in_stream.payload.is_download ? SALT_DOWNLOAD : SALT_UPLOAD;
    stg_item_nxt.action         = in_stream.payload.action;
    stg_item_nxt.sequence_req   = in_stream.payload.sequence_req;
    stg_item_nxt.seed           = in_stream.payload.sequence_req[31:0]
                                ^ in_stream.payload.sequence_req[63:32]
                                ^ sid_mix ^ salt;
    stg_item_nxt.is_warmup      = in_stream.payload.is_warmup;
    stg_item_nxt.payload_length = in_stream.payload.payload_length;
    stg_item_nxt.send_valid     = (in_stream.payload.send_time_us != 64'd0);
    stg_item_nxt.transit        =
      (in_stream.payload.arrival_time_us > in_stream.payload.send_time_us) ?
      (in_stream.payload.arrival_time_us - in_stream.payload.send_time_us) : 64'd0;
    stg_item_nxt.data_byte      = in_stream.payload.data_byte;
  end

  // Stage occupancy
  always_comb begin
    if (in_accept) begin
      stg_vld_nxt = 1'b1;
    end else if (adv) begin
      stg_vld_nxt = 1'b0;
    end else begin
      stg_vld_nxt = stg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stg_item_r <= stg_item_nxt;
    end
  end

  assign stg_vld  = stg_vld_r;
  assign stg_item = stg_item_r;

  // A held item is neither dropped nor overwritten
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r && !adv |=> stg_vld_r && $stable(stg_item_r))
    else $error("capture stage lost or changed a stalled item");

endmodule

// ----- rtl/trc_pattern.sv -----
module trc_pattern (
  input  trc_pkg::pat_req_t pat_req,
  output logic [7:0]        pattern_byte
);
  import trc_pkg::*;

  logic [31:0] v;
  logic [31:0] w;
  logic [31:0] p;

  // h(v): xor-shift, multiply, then the low byte is xored with bits 23:16
  always_comb begin
    v = pat_req.seed + {16'd0, pat_req.index};
    w = v ^ (v >> MIX_SHIFT);
    p = w * MIX_MULT;
    pattern_byte = p[7:0] ^ p[23:16];
  end

endmodule

// ----- rtl/trc_update.sv -----
module trc_update (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               stg_vld,
  input  trc_pkg::stg_item_t stg_item,
  input  logic [7:0]         pattern_byte,
  output trc_pkg::pat_req_t  pat_req,
  output logic               adv,
  trc_out_if.source          out_stream
);
  import trc_pkg::*;

  // Sequence, counters and jitter state
  logic [63:0] exp_r, exp_nxt;
  logic [63:0] bytes_r, bytes_nxt;
  logic [63:0] pkt_r, pkt_nxt;
  logic [63:0] valid_r, valid_nxt;
  logic [63:0] lost_r, lost_nxt;
  logic [63:0] dup_r, dup_nxt;
  logic [63:0] ooo_r, ooo_nxt;
  logic [63:0] err_r, err_nxt;
  logic [63:0] jit_r, jit_nxt;
  logic [63:0] prev_r, prev_nxt;
  // Open frame state
  logic [31:0] seed_r, seed_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic        mis_r, mis_nxt;
  logic        warm_r, warm_nxt;
  // Result register
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic        fire;
  logic        emit;
  logic        final_flag;
  logic        abandon_err;
  logic        mis_new;
  logic [64:0] seq_sub;
  logic        seq_gt;
  logic        seq_eq;
  logic [64:0] tr_sub;
  logic [63:0] tr_abs;
  logic [DIFF_BITS-1:0] tr_sat;
  logic [63:0] d_fix;
  logic [64:0] j_sub;
  logic [63:0] j_dn;
  logic [63:0] jit_new;

  assign adv  = !out_valid_r || out_stream.ready;
  assign fire = stg_vld && adv;

  assign pat_req.seed  = seed_r;
  assign pat_req.index = idx_r;

  // Sequence compare and the filtered transit difference
  always_comb begin
    seq_sub = {1'b0, stg_item.sequence_req} - {1'b0, exp_r};
    seq_eq  = (seq_sub[63:0] == 64'd0);
    seq_gt  = !seq_sub[64] && !seq_eq;

    tr_sub  = {1'b0, stg_item.transit} - {1'b0, prev_r};
    tr_abs  = tr_sub[64] ? (prev_r - stg_item.transit) : tr_sub[63:0];
    tr_sat  = (|tr_abs[63:DIFF_BITS]) ? {DIFF_BITS{1'b1}} : tr_abs[DIFF_BITS-1:0];
    d_fix   = {tr_sat, {FRAC_BITS{1'b0}}};
    j_sub   = {1'b0, d_fix} - {1'b0, jit_r};
    j_dn    = jit_r - d_fix;
    jit_new = !j_sub[64] ? (jit_r + (j_sub[63:0] >> JITTER_SHIFT))
                         : (jit_r - (j_dn >> JITTER_SHIFT));
  end

  assign abandon_err = (rem_r != 16'd0) && !warm_r;
  assign mis_new     = mis_r || (stg_item.data_byte != pattern_byte);

  // Per-item state update
  always_comb begin
    exp_nxt    = exp_r;
    bytes_nxt  = bytes_r;
    pkt_nxt    = pkt_r;
    valid_nxt  = valid_r;
    lost_nxt   = lost_r;
    dup_nxt    = dup_r;
    ooo_nxt    = ooo_r;
    err_nxt    = err_r;
    jit_nxt    = jit_r;
    prev_nxt   = prev_r;
    seed_nxt   = seed_r;
    idx_nxt    = idx_r;
    rem_nxt    = rem_r;
    mis_nxt    = mis_r;
    warm_nxt   = warm_r;
    emit       = 1'b0;
    final_flag = 1'b0;

    if (fire) begin
      case (stg_item.action)
        ACT_HEADER: begin
          if (abandon_err) begin
            err_nxt = err_r + 64'd1;
          end
          seed_nxt = stg_item.seed;
          warm_nxt = stg_item.is_warmup;
          mis_nxt  = 1'b0;
          idx_nxt  = 16'd0;
          rem_nxt  = stg_item.payload_length;
          if (!stg_item.is_warmup) begin
            if (seq_eq) begin
              exp_nxt = exp_r + 64'd1;
            end else if (seq_gt) begin
              lost_nxt = lost_r + seq_sub[63:0];
              ooo_nxt  = ooo_r + 64'd1;
              exp_nxt  = stg_item.sequence_req + 64'd1;
            end else begin
              dup_nxt = dup_r + 64'd1;
              ooo_nxt = ooo_r + 64'd1;
            end
            bytes_nxt = bytes_r + {48'd0, stg_item.payload_length};
            pkt_nxt   = pkt_r + 64'd1;
            if (stg_item.send_valid) begin
              if (prev_r != 64'd0) begin
                jit_nxt = jit_new;
              end
              prev_nxt = stg_item.transit;
            end
            // Empty frame completes at its header and counts as valid
            if (stg_item.payload_length == 16'd0) begin
              valid_nxt = valid_r + 64'd1;
              warm_nxt  = 1'b0;
              emit      = 1'b1;
            end
          end
        end
        ACT_BYTE: begin
          // Stray bytes with no open frame are dropped
          if (rem_r != 16'd0) begin
            mis_nxt = mis_new;
            idx_nxt = idx_r + 16'd1;
            rem_nxt = rem_r - 16'd1;
            if (rem_r == 16'd1) begin
              if (!warm_r) begin
                if (mis_new) begin
                  err_nxt = err_r + 64'd1;
                end else begin
                  valid_nxt = valid_r + 64'd1;
                end
                emit = 1'b1;
              end
              mis_nxt  = 1'b0;
              warm_nxt = 1'b0;
              idx_nxt  = 16'd0;
            end
          end
        end
        ACT_END: begin
          if (abandon_err) begin
            err_nxt = err_r + 64'd1;
          end
          rem_nxt  = 16'd0;
          idx_nxt  = 16'd0;
          mis_nxt  = 1'b0;
          warm_nxt = 1'b0;
          if (seq_gt) begin
            lost_nxt = lost_r + seq_sub[63:0];
            exp_nxt  = stg_item.sequence_req;
          end
          emit       = 1'b1;
          final_flag = 1'b1;
        end
        default: begin
          // unused action code: no effect
        end
      endcase
    end
  end

  // Result snapshot from the updated counters
  always_comb begin
    out_item_nxt.byte_count         = bytes_nxt;
    out_item_nxt.packet_count       = pkt_nxt;
    out_item_nxt.valid_count        = valid_nxt;
    out_item_nxt.lost_count         = lost_nxt;
    out_item_nxt.duplicate_count    = dup_nxt;
    out_item_nxt.out_of_order_count = ooo_nxt;
    out_item_nxt.error_count        = err_nxt;
    out_item_nxt.jitter_avg_us      = jit_nxt >> FRAC_BITS;
    out_item_nxt.final_report       = final_flag;

    if (fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stream.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r       <= 64'd0;
      bytes_r     <= 64'd0;
      pkt_r       <= 64'd0;
      valid_r     <= 64'd0;
      lost_r      <= 64'd0;
      dup_r       <= 64'd0;
      ooo_r       <= 64'd0;
      err_r       <= 64'd0;
      jit_r       <= 64'd0;
      prev_r      <= 64'd0;
      seed_r      <= 32'd0;
      idx_r       <= 16'd0;
      rem_r       <= 16'd0;
      mis_r       <= 1'b0;
      warm_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      exp_r       <= exp_nxt;
      bytes_r     <= bytes_nxt;
      pkt_r       <= pkt_nxt;
      valid_r     <= valid_nxt;
      lost_r      <= lost_nxt;
      dup_r       <= dup_nxt;
      ooo_r       <= ooo_nxt;
      err_r       <= err_nxt;
      jit_r       <= jit_nxt;
      prev_r      <= prev_nxt;
      seed_r      <= seed_nxt;
      idx_r       <= idx_nxt;
      rem_r       <= rem_nxt;
      mis_r       <= mis_nxt;
      warm_r      <= warm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_stream.valid   = out_valid_r;
  assign out_stream.payload = out_item_r;

  // Closed frame always has its byte position cleared
  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r == 16'd0 |-> idx_r == 16'd0)
    else $error("byte index nonzero with no open frame");

  // Payload bytes never touch the packet counter
  a_byte_no_packet: assert property (@(posedge clk) disable iff (!rst_n)
    fire && stg_item.action == ACT_BYTE |=> pkt_r == $past(pkt_r))
    else $error("packet counter changed on a payload byte");

  // A new result only comes from a transaction that emits
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire && emit))
    else $error("result raised without a source transaction");

  // End marker result carries the final flag
  a_final_flag: assert property (@(posedge clk) disable iff (!rst_n)
    fire && stg_item.action == ACT_END |=> out_valid_r && out_item_r.final_report)
    else $error("end marker result missing final flag");

endmodule
